// ===== rtl/swbt_pkg.sv =====
// package for the single-wire bus transceiver
// holds op codes, register indexes, result types and the syndrome table
package swbt_pkg;
    localparam logic [2:0] OP_TICK = 3'd0;
    localparam logic [2:0] OP_LOAD = 3'd1;
    localparam logic [2:0] OP_ABORT = 3'd2;
    localparam logic [2:0] OP_CLR_RX = 3'd3;
    localparam logic [2:0] OP_CLR_TX = 3'd4;
    localparam logic [2:0] OP_FORCE = 3'd5;
    localparam logic [2:0] OP_RELEASE = 3'd6;

    localparam logic [1:0] REG_PRIO = 2'd0;
    localparam logic [1:0] REG_BIT = 2'd1;
    localparam logic [1:0] REG_SLOW = 2'd2;
    localparam logic [1:0] REG_MS = 2'd3;

    typedef struct packed {
        logic [2:0] op;
        logic       line_in;
        logic [7:0] data_high;
        logic [7:0] data_low;
        logic [2:0] layer;
        logic [2:0] length_code;
    } t_in_item;

    typedef struct packed {
        logic       line_drive;
        logic [7:0] tx_pending;
        logic [7:0] rx_flags;
        logic [7:0] rx_high;
        logic [7:0] rx_low;
        logic [3:0] rx_layer;
        logic       bus_error;
        logic [7:0] idle_ticks;
        logic [7:0] low_ticks;
    } t_out_item;

    typedef struct packed {
        logic [7:0] prio;
        logic [6:0] bit_p;
        logic [6:0] slow_p;
        logic [5:0] ms;
    } t_cfg;

    function automatic logic [7:0] syn_tab(input logic [4:0] idx);
        logic [7:0] v;
        begin
            case (idx)
                5'd1: v = 8'h80;
                5'd2: v = 8'h8F;
                5'd3: v = 8'h8E;
                5'd4: v = 8'h8D;
                5'd5: v = 8'h8B;
                5'd6: v = 8'h87;
                5'd7: v = 8'h8C;
                5'd8: v = 8'h8A;
                5'd9: v = 8'h89;
                5'd10: v = 8'h86;
                5'd11: v = 8'h85;
                5'd12: v = 8'h83;
                5'd13: v = 8'h88;
                5'd14: v = 8'h84;
                5'd15: v = 8'h82;
                5'd16: v = 8'h81;
                default: v = 8'h00;
            endcase
            return v;
        end
    endfunction
endpackage

// ===== rtl/swbt_if.sv =====
// valid/ready channel carrying one item
// depends on nothing; payload type is a parameter of the interface
interface swbt_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/swbt_core.sv =====
// transceiver state and next-state logic for one item per cycle while i_en is high
// depends on swbt_pkg
module swbt_core import swbt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_res
);
    logic [7:0] r_win, r_hc, r_lc, r_slot, r_txbc, r_retry, r_boff, r_pend, r_rxf;
    logic [7:0] r_rxbc, r_syn;
    logic       r_coll, r_err, r_drv;
    logic [15:0] r_txw, r_txs, r_rxs;
    logic [19:0] r_res;

    logic [7:0] n_win, n_hc, n_lc, n_slot, n_txbc, n_retry, n_boff, n_pend, n_rxf;
    logic [7:0] n_rxbc, n_syn;
    logic       n_coll, n_err, n_drv;
    logic [15:0] n_txw, n_txs, n_rxs;
    logic [19:0] n_res;

    logic [6:0]  unit;
    logic [7:0]  u1, u2, u3;
    logic [8:0]  ms4, ms5, ms6;
    logic [7:0]  hi, lo;
    logic [3:0]  lay;
    logic        lev, prv, tx_done;
    logic [7:0]  acc;
    logic [15:0] w;

    always_comb begin
        n_win = r_win; n_hc = r_hc; n_lc = r_lc; n_slot = r_slot; n_txbc = r_txbc;
        n_retry = r_retry; n_boff = r_boff; n_pend = r_pend; n_rxf = r_rxf;
        n_rxbc = r_rxbc; n_syn = r_syn; n_coll = r_coll; n_err = r_err; n_drv = r_drv;
        n_txw = r_txw; n_txs = r_txs; n_rxs = r_rxs; n_res = r_res;
        unit = 7'd0; u1 = 8'd0; u2 = 8'd0; u3 = 8'd0;
        ms4 = {1'b0, i_cfg.ms, 2'b00};
        ms5 = ms4 + 9'(i_cfg.ms);
        ms6 = ms4 + {2'b0, i_cfg.ms, 1'b0};
        hi = 8'd0; lo = 8'd0; lay = 4'd0; lev = 1'b0; prv = 1'b0;
        tx_done = 1'b0; acc = 8'd0; w = 16'd0;
        case (i_item.op)
            OP_TICK: begin
                n_slot = r_slot + 8'd1;
                n_win = {i_item.line_in, r_win[7:1]};
                if (n_win[7:5] == 3'b101) n_win[6] = 1'b1;
                else if (n_win[7:5] == 3'b010) n_win[6] = 1'b0;
                if (n_win[6]) begin
                    if (n_hc != 8'hFF) n_hc = n_hc + 8'd1;
                    n_err = 1'b0;
                end else begin
                    n_lc = n_lc + 8'd1;
                end
                // transmit
                if (!n_pend[7] && (n_hc < i_cfg.prio || n_pend == 8'd0)) begin
                    tx_done = 1'b1;
                end else begin
                    if (!n_pend[7] && n_win[7]) begin
                        unit = (n_pend[1:0] != 2'b00) ? i_cfg.slow_p : i_cfg.bit_p;
                        n_drv = 1'b1;
                        if (n_pend[4]) n_txbc = 8'd15;
                        else if (n_pend[3]) n_txbc = 8'd16;
                        else if (n_pend[2]) n_txbc = 8'd17;
                        else if (n_pend[1]) n_txbc = 8'd20;
                        else if (n_pend[0]) n_txbc = 8'd23;
                        else if (n_pend[5]) n_txbc = 8'd28;
                        n_pend[7] = 1'b1;
                        n_txs = n_txw;
                        n_slot = {unit, 1'b0};
                    end
                    if (n_boff[6]) begin
                        if (!n_win[7] && !n_drv) begin
                            if (!n_coll) n_coll = 1'b1;
                            else tx_done = 1'b1;
                        end else begin
                            n_coll = 1'b0;
                        end
                    end else begin
                        tx_done = 1'b1;
                    end
                    if (tx_done) begin
                        n_retry = n_retry + 8'd1;
                        if (n_retry[4]) n_pend = 8'd0;
                        n_pend[7] = 1'b0;
                    end else if (n_txbc[5]) begin
                        if ({1'b0, n_slot} >= ms6) begin
                            n_pend = 8'd0;
                            tx_done = 1'b1;
                        end
                    end else begin
                        unit = (n_pend[1:0] != 2'b00) ? i_cfg.slow_p : i_cfg.bit_p;
                        u1 = {1'b0, unit};
                        u2 = {unit, 1'b0};
                        u3 = u1 + u2;
                        if (n_slot == u1) begin
                            if (!n_txs[15]) n_drv = 1'b1;
                            n_txs = {n_txs[14:0], 1'b0};
                        end
                        if (n_slot == u2) n_drv = 1'b1;
                        if (n_slot == u3) begin
                            n_drv = 1'b0;
                            n_txbc = n_txbc + 8'd1;
                            n_slot = 8'd0;
                        end
                    end
                end
                if (tx_done) begin
                    if (n_boff[6]) begin
                        if (!n_pend[7]) n_drv = 1'b0;
                    end else begin
                        n_drv = 1'b1;
                        n_boff = n_boff + 8'd1;
                        if (n_boff[6]) n_drv = 1'b0;
                    end
                end
                // receive
                lev = n_win[6];
                prv = n_win[5];
                if (!n_rxf[7]) begin
                    if (!lev) begin
                        if ({1'b0, n_hc} >= ms6) begin
                            n_rxf[7] = 1'b1;
                            n_syn = 8'd0; n_rxbc = 8'd0; n_lc = 8'd0; n_rxs = 16'd0;
                        end
                        n_hc = 8'd0;
                    end
                end else if ({1'b0, n_lc} >= ms4) begin
                    n_hc = 8'd0;
                    n_rxf[7] = 1'b0;
                    n_err = 1'b1;
                end else if ({1'b0, n_hc} < ms4) begin
                    if (lev && !prv) begin
                        n_rxs = {n_rxs[14:0], 1'b0};
                        if (n_hc > n_lc) begin
                            n_rxs[0] = 1'b1;
                            if (n_rxbc < 8'd18) n_syn = n_syn ^ syn_tab(n_rxbc[4:0]);
                        end
                        n_rxbc = n_rxbc + 8'd1;
                        n_hc = 8'd0;
                        n_lc = 8'd0;
                        if ((n_rxbc == 8'd17 && n_syn != 8'd0) || n_rxbc > 8'd17) begin
                            n_boff = 8'd0;
                            n_rxf[7] = 1'b0;
                        end
                    end
                end else if (n_pend[7]) begin
                    n_rxf[7] = 1'b0;
                end else if (n_rxbc == 8'd16) begin
                    if (n_syn[7]) begin
                        n_boff = 8'd0;
                        n_rxf[7] = 1'b0;
                    end else if ({1'b0, n_hc} >= ms5) begin
                        n_rxs = {1'b0, n_rxs[13:0], 1'b0};
                        n_rxf[3] = 1'b1;
                        n_res = {n_rxs[15:8], n_rxs[7:4], 4'd0, 1'b0, n_rxs[3:1]};
                        n_rxf[7] = 1'b0;
                    end
                end else begin
                    lay = n_res[3:0];
                    hi = n_rxs[15:8];
                    lo = n_rxs[7:0];
                    case (n_rxbc)
                        8'd4: begin
                            n_rxf[5] = 1'b1; lay = 4'd0; hi = 8'd0; lo[7:4] = 4'd0;
                        end
                        8'd9: begin
                            n_rxf[0] = 1'b1; lay = 4'd0; hi = 8'd0;
                        end
                        8'd12: begin
                            n_rxf[1] = 1'b1; lay = hi[3:0]; hi = 8'd0;
                        end
                        8'd15: begin
                            n_rxf[2] = 1'b1; lay = 4'd0;
                        end
                        8'd17: begin
                            n_rxf[4] = 1'b1; hi[7] = 1'b0; lo[3:0] = 4'd0; lay = 4'd0;
                        end
                        default: ;
                    endcase
                    n_rxs = {hi, lo};
                    n_res = {hi, lo, lay};
                    n_rxf[7] = 1'b0;
                end
            end
            OP_LOAD: begin
                w = {i_item.data_high, i_item.data_low};
                n_retry = 8'd0;
                if (i_item.length_code == 3'd4 || i_item.length_code == 3'd3) begin
                    if (i_item.length_code == 3'd4) w[3:0] = 4'd0;
                    else w[3:0] = {i_item.layer, 1'b0};
                    for (int p = 4; p <= 14; p++)
                        if (w[p]) acc = acc ^ syn_tab(5'(16 - p));
                    if (i_item.length_code == 3'd4) w[3:0] = acc[3:0];
                    acc[6:0] = 7'd0;
                    if (^w[3:0]) acc[7] = ~acc[7];
                    w[15] = w[15] | acc[7];
                end else if (i_item.length_code == 3'd1) begin
                    w = {i_item.layer, w[15:3]};
                end else if (i_item.length_code == 3'd2) begin
                    w = {w[13:0], 2'b00};
                end
                n_txw = w;
                if (i_item.length_code <= 3'd5) n_pend[i_item.length_code] = 1'b1;
            end
            OP_ABORT: n_pend = 8'd0;
            OP_CLR_RX: n_rxf[i_item.length_code] = 1'b0;
            OP_CLR_TX: n_pend[i_item.length_code] = 1'b0;
            OP_FORCE: n_drv = 1'b1;
            OP_RELEASE: begin
                n_drv = 1'b0; n_hc = 8'd0; n_lc = 8'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0; r_hc <= '0; r_lc <= '0; r_slot <= '0; r_txbc <= '0;
            r_retry <= '0; r_boff <= '0; r_pend <= '0; r_rxf <= '0; r_rxbc <= '0;
            r_syn <= '0; r_coll <= 1'b0; r_err <= 1'b0; r_drv <= 1'b0;
            r_txw <= '0; r_txs <= '0; r_rxs <= '0; r_res <= '0;
        end else if (i_en) begin
            r_win <= n_win; r_hc <= n_hc; r_lc <= n_lc; r_slot <= n_slot;
            r_txbc <= n_txbc; r_retry <= n_retry; r_boff <= n_boff; r_pend <= n_pend;
            r_rxf <= n_rxf; r_rxbc <= n_rxbc; r_syn <= n_syn; r_coll <= n_coll;
            r_err <= n_err; r_drv <= n_drv; r_txw <= n_txw; r_txs <= n_txs;
            r_rxs <= n_rxs; r_res <= n_res;
        end
    end

    always_comb begin
        o_res.line_drive = n_drv;
        o_res.tx_pending = n_pend;
        o_res.rx_flags = n_rxf;
        o_res.rx_high = n_res[19:12];
        o_res.rx_low = n_res[11:4];
        o_res.rx_layer = n_res[3:0];
        o_res.bus_error = n_err;
        o_res.idle_ticks = n_hc;
        o_res.low_ticks = n_lc;
    end
endmodule

// ===== rtl/swbt_cfg.sv =====
// configuration registers of the transceiver
// depends on swbt_pkg
module swbt_cfg import swbt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_we,
    input  logic [1:0] i_idx,
    input  logic [7:0] i_data,
    output t_cfg       o_cfg
);
    t_cfg r_cfg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{prio: 8'd40, bit_p: 7'd10, slow_p: 7'd20, ms: 6'd10};
        end else if (i_we) begin
            unique case (i_idx)
                REG_PRIO: r_cfg.prio <= i_data;
                REG_BIT: r_cfg.bit_p <= i_data[6:0];
                REG_SLOW: r_cfg.slow_p <= i_data[6:0];
                REG_MS: r_cfg.ms <= i_data[5:0];
                default: ;
            endcase
        end
    end
    assign o_cfg = r_cfg;
endmodule

// ===== rtl/single_wire_bus_transceiver.sv =====
// One item is taken per clock and its result leaves in the following cycle through an
// output register; a new item is accepted whenever the output register is empty or
// being read, so the sustained rate is one item per cycle while out_ch is read.
// The index port is 2 bits wide. Depends on swbt_pkg, swbt_if, swbt_cfg, swbt_core.
module single_wire_bus_transceiver import swbt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    swbt_if.sink      in_ch,
    swbt_if.source    out_ch
);
    t_cfg      cfg;
    t_out_item res;
    logic      accept;
    logic      r_vld;
    t_out_item r_out;

    swbt_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(i_cfg_we), .i_idx(i_cfg_idx),
        .i_data(i_cfg_data), .o_cfg(cfg)
    );

    assign in_ch.ready = !r_vld || out_ch.ready;
    assign accept = in_ch.valid && in_ch.ready;

    swbt_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(accept), .i_item(in_ch.data),
        .i_cfg(cfg), .o_res(res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (in_ch.ready) begin
            r_vld <= in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= res;
        end
    end

    assign out_ch.valid = r_vld;
    assign out_ch.data = r_out;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("result dropped while stalled");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("input blocked with empty output");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> out_ch.valid)
        else $error("accepted item produced no result");
`endif
endmodule
